### hw/rtl/peer_table_oldest_replace_macros.svh
// ----------------------------------------------------------------------------
// Peer table assertion macros
// Shared concurrent assertion forms for the peer table checkers.
// ----------------------------------------------------------------------------
`ifndef PEER_TABLE_OLDEST_REPLACE_MACROS_SVH
`define PEER_TABLE_OLDEST_REPLACE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PTOR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("peer table assertion failed");

// next-cycle implication, disabled while reset is low
`define PTOR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("peer table assertion failed");

`endif

### hw/rtl/ptor_pkg.sv
// ----------------------------------------------------------------------------
// Peer table package
// Sizes, entry layout, operation and outcome codes, controller interface.
// ----------------------------------------------------------------------------
package ptor_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int MAC_W       = 48;
  localparam int TIME_W      = 32;

  typedef enum logic [1:0] {
    OP_PEER_SEEN = 2'd0,
    OP_PONG      = 2'd1,
    OP_HOST      = 2'd2,
    OP_READ      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OUT_FOUND    = 2'd0,
    OUT_APPENDED = 2'd1,
    OUT_REPLACED = 2'd2,
    OUT_NONE     = 2'd3
  } outcome_e;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] seen;
    logic              relayed;
    logic              pinged;
    logic [TIME_W-1:0] rtt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath commands
  typedef struct packed {
    logic cap;          // capture the input word
    logic host_upd;     // record host activity
    logic ram_re;       // issue a table read
    logic rd_sel_ridx;  // read address is the read index, else scan index
    logic ram_we;       // write the updated entry
    logic idx_inc;      // advance scan index
    logic idx_clr;      // restart scan index
    logic best_upd;     // fold current entry into oldest search
    logic set_hit;      // slot = scan index, found
    logic set_append;   // slot = count, appended
    logic set_best;     // slot = oldest, replaced
    logic out_load;     // load result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_e  in_op;
    logic count_zero;
    logic mac_hit;
    logic scan_last;    // scan index is the last valid entry
    logic full;
    logic idx_last;     // scan index is the last table entry
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/ptor_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/ptor_ctrl.sv
// ----------------------------------------------------------------------------
// Peer table controller
// Sequences match scan, oldest scan, entry update, reads and result handoff.
// ----------------------------------------------------------------------------
module ptor_ctrl import ptor_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MRD  = 3'd1;
  localparam logic [2:0] ST_MCMP = 3'd2;
  localparam logic [2:0] ST_ORD  = 3'd3;
  localparam logic [2:0] ST_OCMP = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_RRD  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          case (sts_i.in_op)
            OP_PEER_SEEN, OP_PONG: begin
              if (sts_i.count_zero) begin
                cmd_o.set_append = 1'b1;
                state_d          = ST_UPD;
              end else begin
                state_d = ST_MRD;
              end
            end
            OP_HOST: begin
              cmd_o.host_upd = 1'b1;
              state_d        = ST_DONE;
            end
            default: state_d = ST_RRD;
          endcase
        end
      end
      ST_MRD: begin
        cmd_o.ram_re = 1'b1;
        state_d      = ST_MCMP;
      end
      ST_MCMP: begin
        if (sts_i.mac_hit) begin
          cmd_o.set_hit = 1'b1;
          state_d       = ST_UPD;
        end else if (sts_i.scan_last) begin
          if (sts_i.full) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_ORD;
          end else begin
            cmd_o.set_append = 1'b1;
            state_d          = ST_UPD;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_MRD;
        end
      end
      ST_ORD: begin
        cmd_o.ram_re = 1'b1;
        state_d      = ST_OCMP;
      end
      ST_OCMP: begin
        cmd_o.best_upd = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.set_best = 1'b1;
          state_d        = ST_UPD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_ORD;
        end
      end
      ST_UPD: begin
        cmd_o.ram_we = 1'b1;
        state_d      = ST_DONE;
      end
      ST_RRD: begin
        cmd_o.ram_re      = 1'b1;
        cmd_o.rd_sel_ridx = 1'b1;
        state_d           = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/ptor_datapath.sv
// ----------------------------------------------------------------------------
// Peer table datapath
// Input capture, table RAM, scan index, oldest tracking, host state, result.
// ----------------------------------------------------------------------------
module ptor_datapath import ptor_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  // input word
  input  logic [1:0]        operation_i,
  input  logic [MAC_W-1:0]  peer_mac_i,
  input  logic [TIME_W-1:0] now_ms_i,
  input  logic [TIME_W-1:0] rtt_ms_i,
  input  logic [IDX_W-1:0]  read_index_i,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TIME_W-1:0] cfg_data_i,
  // result word
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        outcome_o,
  output logic [IDX_W-1:0]  slot_o,
  output logic [CNT_W-1:0]  peer_total_o,
  output logic              host_connected_o,
  output logic              host_seen_ever_o,
  output logic [TIME_W-1:0] host_last_time_o,
  output logic              entry_valid_o,
  output logic [MAC_W-1:0]  entry_mac_o,
  output logic [TIME_W-1:0] entry_last_seen_o,
  output logic              entry_relayed_o,
  output logic              entry_pinged_o,
  output logic [TIME_W-1:0] entry_rtt_o
);

  // captured input word
  op_e               op_q;
  logic [MAC_W-1:0]  mac_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] rtt_q;
  logic [IDX_W-1:0]  ridx_q;

  // scan and lookup state
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [TIME_W-1:0] best_time_q, best_time_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  outcome_e          outcome_q, outcome_d;
  logic              fresh_q, fresh_d;

  // control state
  logic [CNT_W-1:0]  count_q, count_d;
  logic              host_flag_q, host_flag_d;
  logic [TIME_W-1:0] host_time_q, host_time_d;
  logic [TIME_W-1:0] timeout_q, timeout_d;
  logic              out_valid_q, out_valid_d;

  // result payload
  logic [1:0]        res_outcome_q;
  logic [IDX_W-1:0]  res_slot_q;
  logic [CNT_W-1:0]  res_total_q;
  logic              res_conn_q;
  logic              res_seen_q;
  logic [TIME_W-1:0] res_htime_q;
  logic              res_evalid_q;
  entry_t            res_entry_q;

  // RAM signals
  entry_t            rd_entry;
  entry_t            wr_entry;
  logic [ENTRY_W-1:0] rd_word;
  logic [IDX_W-1:0]  raddr;

  logic              older;
  logic              read_ok;
  logic [TIME_W-1:0] host_age;
  logic              is_peer, is_pong;

  ptor_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (slot_q),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.ram_re),
    .raddr_i (raddr),
    .rdata_o (rd_word)
  );

  assign rd_entry = entry_t'(rd_word);
  assign raddr    = cmd_i.rd_sel_ridx ? ridx_q : idx_q;
  assign is_peer  = (op_q == OP_PEER_SEEN);
  assign is_pong  = (op_q == OP_PONG);

  // new entries start with only the current event's flag, existing ones keep their flags
  always_comb begin
    wr_entry.mac  = mac_q;
    wr_entry.seen = now_q;
    if (fresh_q) begin
      wr_entry.relayed = is_peer;
      wr_entry.pinged  = is_pong;
      wr_entry.rtt     = is_pong ? rtt_q : '0;
    end else begin
      wr_entry.relayed = rd_entry.relayed | is_peer;
      wr_entry.pinged  = rd_entry.pinged | is_pong;
      wr_entry.rtt     = is_pong ? rtt_q : rd_entry.rtt;
    end
  end

  // oldest search: first entry seeds, strictly smaller wins
  assign older    = (idx_q == '0) || (rd_entry.seen < best_time_q);
  assign read_ok  = ({1'b0, ridx_q} < count_q);
  assign host_age = now_q - host_time_q;

  // status to controller
  assign sts_o.in_op      = op_e'(operation_i);
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.mac_hit    = (rd_entry.mac == mac_q);
  assign sts_o.scan_last  = ({1'b0, idx_q} == count_q - CNT_W'(1));
  assign sts_o.full       = (count_q == CNT_W'(MAX_ENTRIES));
  assign sts_o.idx_last   = (idx_q == IDX_W'(MAX_ENTRIES - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign cfg_ready_o = 1'b1;

  // next-state logic
  always_comb begin
    idx_d       = idx_q;
    best_idx_d  = best_idx_q;
    best_time_d = best_time_q;
    slot_d      = slot_q;
    outcome_d   = outcome_q;
    fresh_d     = fresh_q;
    count_d     = count_q;
    host_flag_d = host_flag_q;
    host_time_d = host_time_q;
    timeout_d   = timeout_q;
    out_valid_d = out_valid_q;

    if (cfg_valid_i) begin
      timeout_d = cfg_data_i;
    end
    if (cmd_i.cap) begin
      idx_d     = '0;
      slot_d    = '0;
      outcome_d = OUT_NONE;
      fresh_d   = 1'b0;
    end
    if (cmd_i.host_upd) begin
      host_flag_d = 1'b1;
      host_time_d = now_ms_i;
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end
    if (cmd_i.best_upd && older) begin
      best_idx_d  = idx_q;
      best_time_d = rd_entry.seen;
    end
    if (cmd_i.set_hit) begin
      slot_d    = idx_q;
      outcome_d = OUT_FOUND;
      fresh_d   = 1'b0;
    end
    if (cmd_i.set_append) begin
      slot_d    = count_q[IDX_W-1:0];
      outcome_d = OUT_APPENDED;
      fresh_d   = 1'b1;
      count_d   = count_q + CNT_W'(1);
    end
    if (cmd_i.set_best) begin
      slot_d    = older ? idx_q : best_idx_q;
      outcome_d = OUT_REPLACED;
      fresh_d   = 1'b1;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      host_flag_q <= 1'b0;
      host_time_q <= '0;
      timeout_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      host_flag_q <= host_flag_d;
      host_time_q <= host_time_d;
      timeout_q   <= timeout_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q   <= op_e'(operation_i);
      mac_q  <= peer_mac_i;
      now_q  <= now_ms_i;
      rtt_q  <= rtt_ms_i;
      ridx_q <= read_index_i;
    end
    idx_q       <= idx_d;
    best_idx_q  <= best_idx_d;
    best_time_q <= best_time_d;
    slot_q      <= slot_d;
    outcome_q   <= outcome_d;
    fresh_q     <= fresh_d;
    if (cmd_i.out_load) begin
      res_outcome_q <= outcome_q;
      res_slot_q    <= slot_q;
      res_total_q   <= count_q;
      res_conn_q    <= host_flag_q && (host_age <= timeout_q);
      res_seen_q    <= host_flag_q;
      res_htime_q   <= host_time_q;
      res_evalid_q  <= (op_q == OP_READ) && read_ok;
      if ((op_q == OP_READ) && read_ok) begin
        res_entry_q <= rd_entry;
      end else begin
        res_entry_q <= '0;
      end
    end
  end

  // result ports
  assign out_valid_o       = out_valid_q;
  assign outcome_o         = res_outcome_q;
  assign slot_o            = res_slot_q;
  assign peer_total_o      = res_total_q;
  assign host_connected_o  = res_conn_q;
  assign host_seen_ever_o  = res_seen_q;
  assign host_last_time_o  = res_htime_q;
  assign entry_valid_o     = res_evalid_q;
  assign entry_mac_o       = res_entry_q.mac;
  assign entry_last_seen_o = res_entry_q.seen;
  assign entry_relayed_o   = res_entry_q.relayed;
  assign entry_pinged_o    = res_entry_q.pinged;
  assign entry_rtt_o       = res_entry_q.rtt;

endmodule

### hw/rtl/peer_table_oldest_replace.sv
// ----------------------------------------------------------------------------
// Peer table with oldest-entry replacement
// Sixteen-entry MAC-keyed peer table with host activity tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one word per event: peer
//   seen, discovery pong, host activity or entry read. Each word gives one
//   result word on the output channel (out_valid_o/out_ready_i).
//   cfg_valid_i/cfg_data_i write the host timeout; write it only while idle.
// Sequencing is set by the table RAM's one read port; entries are scanned
// one at a time, each read and then compared:
//   host activity: no table access.  entry read: one RAM read.
//   peer/pong: entries scanned up to the match or the count;
//   on a full table with no match an oldest search over all 16 follows.
// One word is in process at a time; the next is taken once the current
// result is in the output register, even if that result is still stalled.
// Reset empties the table (count zero), clears host state and the timeout;
// no clearing pass over the RAM is needed. A stalled receiver holds the
// result word stable and blocks only after one further word has finished.
// ----------------------------------------------------------------------------
module peer_table_oldest_replace import ptor_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [MAC_W-1:0]  peer_mac_i,
  input  logic [TIME_W-1:0] now_ms_i,
  input  logic [TIME_W-1:0] rtt_ms_i,
  input  logic [IDX_W-1:0]  read_index_i,
  // configuration channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TIME_W-1:0] cfg_data_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        outcome_o,
  output logic [IDX_W-1:0]  slot_o,
  output logic [CNT_W-1:0]  peer_total_o,
  output logic              host_connected_o,
  output logic              host_seen_ever_o,
  output logic [TIME_W-1:0] host_last_time_o,
  output logic              entry_valid_o,
  output logic [MAC_W-1:0]  entry_mac_o,
  output logic [TIME_W-1:0] entry_last_seen_o,
  output logic              entry_relayed_o,
  output logic              entry_pinged_o,
  output logic [TIME_W-1:0] entry_rtt_o
);

  cmd_t cmd;
  sts_t sts;

  ptor_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptor_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .operation_i       (operation_i),
    .peer_mac_i        (peer_mac_i),
    .now_ms_i          (now_ms_i),
    .rtt_ms_i          (rtt_ms_i),
    .read_index_i      (read_index_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .outcome_o         (outcome_o),
    .slot_o            (slot_o),
    .peer_total_o      (peer_total_o),
    .host_connected_o  (host_connected_o),
    .host_seen_ever_o  (host_seen_ever_o),
    .host_last_time_o  (host_last_time_o),
    .entry_valid_o     (entry_valid_o),
    .entry_mac_o       (entry_mac_o),
    .entry_last_seen_o (entry_last_seen_o),
    .entry_relayed_o   (entry_relayed_o),
    .entry_pinged_o    (entry_pinged_o),
    .entry_rtt_o       (entry_rtt_o)
  );

endmodule

### hw/rtl/ptor_checker.sv
// ----------------------------------------------------------------------------
// Peer table checker
// Port-level assertions on the result word, bound to the top level.
// ----------------------------------------------------------------------------
`include "peer_table_oldest_replace_macros.svh"

module ptor_checker import ptor_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        outcome_o,
  input logic [IDX_W-1:0]  slot_o,
  input logic [CNT_W-1:0]  peer_total_o,
  input logic              host_connected_o,
  input logic              host_seen_ever_o,
  input logic              entry_valid_o,
  input logic [MAC_W-1:0]  entry_mac_o
);

  // a stalled result word holds
  `PTOR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(slot_o) && $stable(outcome_o) && $stable(entry_mac_o))

  // an appended entry is always the last valid one
  `PTOR_ASSERT_IMP(a_append_slot, clk_i, rst_ni, out_valid_o && (outcome_o == OUT_APPENDED), ({1'b0, slot_o} + CNT_W'(1)) == peer_total_o)

  // replacement only happens on a full table
  `PTOR_ASSERT_IMP(a_replace_full, clk_i, rst_ni, out_valid_o && (outcome_o == OUT_REPLACED), peer_total_o == CNT_W'(MAX_ENTRIES))

  // no lookup means slot zero; invalid reads return zero
  `PTOR_ASSERT_IMP(a_no_lookup, clk_i, rst_ni, out_valid_o && (outcome_o == OUT_NONE), slot_o == '0)
  `PTOR_ASSERT_IMP(a_conn_seen, clk_i, rst_ni, out_valid_o && (host_connected_o || (entry_mac_o != '0)), (!host_connected_o || host_seen_ever_o) && (entry_valid_o || (entry_mac_o == '0)))

endmodule

bind peer_table_oldest_replace ptor_checker u_ptor_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .outcome_o        (outcome_o),
  .slot_o           (slot_o),
  .peer_total_o     (peer_total_o),
  .host_connected_o (host_connected_o),
  .host_seen_ever_o (host_seen_ever_o),
  .entry_valid_o    (entry_valid_o),
  .entry_mac_o      (entry_mac_o)
);
